>>> src/ddt_pkg.sv
package ddt_pkg;

  // Token codes
  localparam logic [5:0] TK_LET_A   = 6'd0;
  localparam logic [5:0] TK_LET_I   = 6'd8;
  localparam logic [5:0] TK_LET_Q   = 6'd16;
  localparam logic [5:0] TK_LET_U   = 6'd20;
  localparam logic [5:0] TK_LET_W   = 6'd22;
  localparam logic [5:0] TK_AA      = 6'd26;
  localparam logic [5:0] TK_AI      = 6'd27;
  localparam logic [5:0] TK_AU      = 6'd28;
  localparam logic [5:0] TK_EE      = 6'd29;
  localparam logic [5:0] TK_EEU     = 6'd30;
  localparam logic [5:0] TK_EI      = 6'd31;
  localparam logic [5:0] TK_EU      = 6'd32;
  localparam logic [5:0] TK_IE      = 6'd33;
  localparam logic [5:0] TK_IEU     = 6'd34;
  localparam logic [5:0] TK_IJ      = 6'd35;
  localparam logic [5:0] TK_OE      = 6'd36;
  localparam logic [5:0] TK_OO      = 6'd37;
  localparam logic [5:0] TK_OU      = 6'd38;
  localparam logic [5:0] TK_UI      = 6'd39;
  localparam logic [5:0] TK_UU      = 6'd40;
  localparam logic [5:0] TK_CH      = 6'd41;
  localparam logic [5:0] TK_BREAK   = 6'd42;
  localparam logic [5:0] TK_INVALID = 6'd43;

  // Fill byte read past the end of a word
  localparam logic [7:0] PAD_BYTE = 8'h30;

  typedef struct packed {
    logic [7:0] char_in;
    logic       word_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0] token;
    logic [1:0] token_chars;
    logic       invalid_char;
    logic       last_token;
  } out_word_t;

  // Up to four tokens from one input word
  typedef struct packed {
    logic [2:0]           count;
    out_word_t [3:0]      item;
  } batch_t;

  // Outcome of one rule at one position
  typedef struct packed {
    logic [2:0][5:0] tok;
    logic [1:0]      ntok;
    logic [2:0]      used;
  } rule_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC0 && c <= 8'hDF)) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] strip_umlaut(input logic [7:0] c);
    case (c)
      8'hC4, 8'hE4: return "a";
      8'hCB, 8'hEB: return "e";
      8'hCF, 8'hEF: return "i";
      8'hD6, 8'hF6: return "o";
      8'hDC, 8'hFC: return "u";
      default:      return c;
    endcase
  endfunction

  function automatic logic [1:0] token_size(input logic [5:0] tok);
    if (tok < TK_AA || tok == TK_INVALID) return 2'd1;
    if (tok == TK_BREAK) return 2'd0;
    if (tok == TK_EEU || tok == TK_IEU) return 2'd3;
    return 2'd2;
  endfunction

  function automatic rule_t mk_rule(input logic [2:0] used, input logic [1:0] ntok,
                                    input logic [5:0] t0, input logic [5:0] t1,
                                    input logic [5:0] t2);
    rule_t r;
    r.used   = used;
    r.ntok   = ntok;
    r.tok[0] = t0;
    r.tok[1] = t1;
    r.tok[2] = t2;
    return r;
  endfunction

  // Greedy ordered cluster rules; a is the head byte (umlaut stripped here)
  function automatic rule_t apply_rule(input logic [7:0] a_raw, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
    logic [7:0] a;
    a = strip_umlaut(a_raw);
    if (a == "i" && b == "e" && c == "u" && d == "w")
      return mk_rule(3'd4, 2'd2, TK_IEU, TK_LET_W, 6'd0);
    if (a == "a" && b == "a" && c == "i") return mk_rule(3'd3, 2'd2, TK_AA, TK_LET_I, 6'd0);
    if (a == "a" && b == "i" && c == "j") return mk_rule(3'd3, 2'd2, TK_LET_A, TK_IJ, 6'd0);
    if (a == "e" && b == "e" && c == "u") return mk_rule(3'd3, 2'd1, TK_EEU, 6'd0, 6'd0);
    if (a == "i" && b == "e" && c == "e") return mk_rule(3'd3, 2'd2, TK_LET_I, TK_EE, 6'd0);
    if (a == "i" && b == "e" && c == "u") return mk_rule(3'd3, 2'd2, TK_LET_I, TK_EU, 6'd0);
    if (a == "o" && b == "e" && c == "i") return mk_rule(3'd3, 2'd2, TK_OE, TK_LET_I, 6'd0);
    if (a == "o" && b == "o" && c == "i") return mk_rule(3'd3, 2'd2, TK_OO, TK_LET_I, 6'd0);
    if (a == "q" && b == "u" && c == "i")
      return mk_rule(3'd3, 2'd3, TK_LET_Q, TK_LET_U, TK_LET_I);
    if (a == "a" && b == "a") return mk_rule(3'd2, 2'd1, TK_AA, 6'd0, 6'd0);
    if (a == "a" && b == "i") return mk_rule(3'd2, 2'd1, TK_AI, 6'd0, 6'd0);
    if (a == "a" && b == "u") return mk_rule(3'd2, 2'd1, TK_AU, 6'd0, 6'd0);
    if (a == "c" && b == "h") return mk_rule(3'd2, 2'd1, TK_CH, 6'd0, 6'd0);
    if (a == "e" && b == "e") return mk_rule(3'd2, 2'd1, TK_EE, 6'd0, 6'd0);
    if (a == "e" && b == "i") return mk_rule(3'd2, 2'd1, TK_EI, 6'd0, 6'd0);
    if (a == "e" && b == "u") return mk_rule(3'd2, 2'd1, TK_EU, 6'd0, 6'd0);
    if (a == "i" && b == "e") return mk_rule(3'd2, 2'd1, TK_IE, 6'd0, 6'd0);
    if (a == "i" && b == "j") return mk_rule(3'd2, 2'd1, TK_IJ, 6'd0, 6'd0);
    if (a == "o" && b == "e") return mk_rule(3'd2, 2'd1, TK_OE, 6'd0, 6'd0);
    if (a == "o" && b == "o") return mk_rule(3'd2, 2'd1, TK_OO, 6'd0, 6'd0);
    if (a == "o" && b == "u") return mk_rule(3'd2, 2'd1, TK_OU, 6'd0, 6'd0);
    if (a == "u" && b == "i") return mk_rule(3'd2, 2'd1, TK_UI, 6'd0, 6'd0);
    if (a == "u" && b == "u") return mk_rule(3'd2, 2'd1, TK_UU, 6'd0, 6'd0);
    if (a == ".") return mk_rule(3'd1, 2'd1, TK_BREAK, 6'd0, 6'd0);
    if (a >= "a" && a <= "z") return mk_rule(3'd1, 2'd1, 6'(a - 8'h61), 6'd0, 6'd0);
    return mk_rule(3'd1, 2'd1, TK_INVALID, 6'd0, 6'd0);
  endfunction

endpackage

>>> src/ddt_core.sv
module ddt_core
  import ddt_pkg::*;
(
  input  logic [2:0][7:0] la_bytes,
  input  logic [1:0]      la_count,
  input  in_word_t        in_word,
  output batch_t          batch,
  output logic [2:0][7:0] la_bytes_next,
  output logic [1:0]      la_count_next
);

  logic [7:0]      folded;
  logic [2:0]      n;
  logic [6:0][7:0] win;
  rule_t [3:0]     rules;
  rule_t           r;
  logic [2:0]      p;
  logic [2:0]      pos;
  logic [2:0]      used0;

  assign folded = fold_case(in_word.char_in);
  assign n      = {1'b0, la_count} + 3'd1;
  assign used0  = rules[0].used;

  // Known bytes, padded past the end
  always_comb begin
    for (int i = 0; i < 7; i++) win[i] = PAD_BYTE;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < la_count) win[i] = la_bytes[i];
    end
    win[{1'b0, la_count}] = folded;
  end

  // One rule evaluated at every start position
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      rules[q] = apply_rule(win[q], win[q+1], win[q+2], win[q+3]);
    end
  end

  // Chain the rules from the head; at most four steps
  always_comb begin
    batch = '0;
    p     = 3'd0;
    pos   = 3'd0;
    r     = '0;
    for (int j = 0; j < 4; j++) begin
      if ((in_word.word_end && p < n) || (!in_word.word_end && j == 0 && n == 3'd4)) begin
        r = rules[p[1:0]];
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < r.ntok && pos < 3'd4) begin
            batch.item[pos[1:0]].token        = r.tok[k];
            batch.item[pos[1:0]].token_chars  = token_size(r.tok[k]);
            batch.item[pos[1:0]].invalid_char = (r.tok[k] == TK_INVALID);
            pos = pos + 3'd1;
          end
        end
        p = p + r.used;
      end
    end
    batch.count = pos;
    if (in_word.word_end && pos != 3'd0) begin
      batch.item[pos[1:0] - 2'd1].last_token = 1'b1;
    end
  end

  // Lookahead update
  always_comb begin
    la_bytes_next = la_bytes;
    la_count_next = la_count;
    if (in_word.word_end) begin
      la_count_next = 2'd0;
    end else if (n == 3'd4) begin
      for (int i = 0; i < 3; i++) begin
        if (3'(i) + used0 < 3'd4) la_bytes_next[i] = win[3'(i) + used0];
      end
      la_count_next = 2'(3'd4 - used0);
    end else begin
      la_bytes_next[la_count] = folded;
      la_count_next = n[1:0];
    end
  end

endmodule

>>> src/ddt_out.sv
module ddt_out
  import ddt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  batch_t    batch_in,
  output logic      free,
  output logic      tok_valid,
  input  logic      tok_ready,
  output out_word_t tok_word
);

  logic [2:0]      count;
  logic [2:0]      count_next;
  out_word_t [3:0] items;
  out_word_t [3:0] items_next;
  logic            fire;

  assign tok_valid = (count != 3'd0);
  assign tok_word  = items[0];
  assign fire      = tok_valid && tok_ready;
  assign free      = (count == 3'd0) || (count == 3'd1 && fire);

  always_comb begin
    items_next = items;
    count_next = count;
    if (fire) begin
      for (int i = 0; i < 3; i++) items_next[i] = items[i+1];
      count_next = count - 3'd1;
    end
    if (load && batch_in.count != 3'd0) begin
      items_next = batch_in.item;
      count_next = batch_in.count;
    end
  end

  always_ff @(posedge clk) begin
    items <= items_next;
    if (rst) begin
      count <= 3'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

>>> src/dutch_digraph_tokenizer.sv
// Channel  Direction  Word         Handshake
// char     in         in_word_t    char_valid / char_ready
// tok      out        out_word_t   tok_valid  / tok_ready
//
// A byte is held in the input register, then the rule logic turns it
// (with up to three held bytes) into zero to four tokens in the output batch.
// One byte per cycle while the batch keeps draining; tokens leave the batch
// in order, and bytes that make no token pass meanwhile.
// Reset (rst, synchronous) empties the input register, lookahead and batch.
// A stalled tok port holds the batch; the input stalls only when a byte
// would make tokens and the batch is not free by the end of the cycle.
module dutch_digraph_tokenizer
  import ddt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_ready,
  input  in_word_t  char_word,
  output logic      tok_valid,
  input  logic      tok_ready,
  output out_word_t tok_word
);

  // Input register
  logic     in_vq;
  in_word_t in_q;

  // Lookahead: folded bytes waiting for a rule
  logic [2:0][7:0] la_bytes;
  logic [1:0]      la_count;
  logic [2:0][7:0] la_bytes_next;
  logic [1:0]      la_count_next;

  batch_t core_batch;
  logic   batch_free;
  logic   proc;

  // The held byte is processed when it makes no token or the batch frees up
  assign proc       = in_vq && (core_batch.count == 3'd0 || batch_free);
  assign char_ready = !in_vq || proc;

  ddt_core u_core (
    .la_bytes      (la_bytes),
    .la_count      (la_count),
    .in_word       (in_q),
    .batch         (core_batch),
    .la_bytes_next (la_bytes_next),
    .la_count_next (la_count_next)
  );

  ddt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (proc),
    .batch_in  (core_batch),
    .free      (batch_free),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_word  (tok_word)
  );

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) in_q <= char_word;
    if (proc) la_bytes <= la_bytes_next;
    if (rst) begin
      in_vq    <= 1'b0;
      la_count <= 2'd0;
    end else begin
      if (char_valid && char_ready) begin
        in_vq <= 1'b1;
      end else if (proc) begin
        in_vq <= 1'b0;
      end
      if (proc) la_count <= la_count_next;
    end
  end

  // A word end always yields at least one token
  a_end_makes_token: assert property (@(posedge clk) disable iff (rst)
    (in_vq && in_q.word_end) |-> core_batch.count != 3'd0)
    else $error("word end produced no token");

  // Never more than four tokens per byte
  a_batch_bound: assert property (@(posedge clk) disable iff (rst)
    in_vq |-> core_batch.count <= 3'd4)
    else $error("token batch overflow");

  // Lookahead is empty after a word end
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && in_q.word_end) |=> la_count == 2'd0)
    else $error("lookahead not flushed");

  // A processed byte that makes tokens leaves a valid token at the output
  a_no_lost_batch: assert property (@(posedge clk) disable iff (rst)
    (proc && core_batch.count != 3'd0) |=> tok_valid)
    else $error("batch dropped");

endmodule
